>>> hdl/erss_pkg.sv
package erss_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 24;

  // Multiplier operand width: one sign bit above the widest operand.
  localparam int MUL_BITS  = (SAMPLE_BITS > COEF_BITS ? SAMPLE_BITS : COEF_BITS) + 1;
  localparam int PROD_BITS = 2 * MUL_BITS;

  // Unity gain and the divisor guard, both in Q1.(SAMPLE_BITS-1).
  localparam logic [SAMPLE_BITS-1:0] ONE_Q = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] EPS_Q = SAMPLE_BITS'(8);

  // Quotient bits produced by the divider when the ratio is below unity.
  localparam int DIV_STEPS = SAMPLE_BITS - 1;
  localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

  // Configuration register indexes (byte address = 4 * index).
  localparam int ADDR_BITS = 5;
  localparam logic [2:0] REG_BYPASS       = 3'd0;
  localparam logic [2:0] REG_FAST_COEF    = 3'd1;
  localparam logic [2:0] REG_SLOW_ATTACK  = 3'd2;
  localparam logic [2:0] REG_SLOW_RELEASE = 3'd3;
  localparam logic [2:0] REG_GAIN_SMOOTH  = 3'd4;

  localparam logic [COEF_BITS-1:0] FAST_COEF_RST    = COEF_BITS'(16603360);
  localparam logic [COEF_BITS-1:0] SLOW_ATTACK_RST  = COEF_BITS'(16603360);
  localparam logic [COEF_BITS-1:0] SLOW_RELEASE_RST = COEF_BITS'(16707456);
  localparam logic [COEF_BITS-1:0] GAIN_SMOOTH_RST  = COEF_BITS'(16707456);

endpackage

>>> hdl/envelope_ratio_swell_shaper_core.sv
// Frames are accepted only while idle, so a new frame waits until the last one is handed to the
// output register. Each channel uses the shared multiplier and the one-bit-per-cycle restoring
// divider (23 steps per channel); the divider is skipped when the channel's gain ratio clamps to
// unity, and bypass frames skip both.
// A finished frame waits in the output register while the next frame is accepted and worked on.
// Reset (rst, synchronous, active high) sets bypass on, loads default coefficients, zeroes both
// envelope followers and sets the smoothed gain of both channels to unity.
module envelope_ratio_swell_shaper_core (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] left_in, [47:24] right_in
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] left_out, [47:24] right_out
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [erss_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SB = erss_pkg::SAMPLE_BITS;
  localparam int CB = erss_pkg::COEF_BITS;
  localparam int MB = erss_pkg::MUL_BITS;
  localparam int PB = erss_pkg::PROD_BITS;
  localparam int NB = erss_pkg::CNT_BITS;

  // Sequencer codes. Each channel walks LOAD through ORND; PUSH hands the frame over.
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_LOAD    = 4'd1;
  localparam logic [3:0] ST_FAST    = 4'd2;
  localparam logic [3:0] ST_SLOW    = 4'd3;
  localparam logic [3:0] ST_SEUPD   = 4'd4;
  localparam logic [3:0] ST_DIVINIT = 4'd5;
  localparam logic [3:0] ST_DIV     = 4'd6;
  localparam logic [3:0] ST_GMUL    = 4'd7;
  localparam logic [3:0] ST_GUPD    = 4'd8;
  localparam logic [3:0] ST_OMUL    = 4'd9;
  localparam logic [3:0] ST_ORND    = 4'd10;
  localparam logic [3:0] ST_PUSH    = 4'd11;

  // Rounding offsets for the follower update and for the output scaling.
  localparam logic signed [PB-1:0] POLE_HALF = PB'(1) <<< (CB - 1);
  localparam logic signed [PB-1:0] OUT_HALF  = PB'(1) <<< (SB - 2);
  localparam logic signed [PB-SB:0] SAT_MAX  = (PB-SB+1)'((1 <<< (SB - 1)) - 1);
  localparam logic signed [PB-SB:0] SAT_MIN  = -((PB-SB+1)'(1) <<< (SB - 1));

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so the access phase never
  // waits and a write lands at the psel & penable & pwrite edge.
  // ---------------------------------------------------------------------------
  logic          bypass_enable;
  logic [CB-1:0] fast_coef;
  logic [CB-1:0] slow_attack_coef;
  logic [CB-1:0] slow_release_coef;
  logic [CB-1:0] gain_smooth_coef;
  logic [2:0]    reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[erss_pkg::ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass_enable     <= 1'b1;
      fast_coef         <= erss_pkg::FAST_COEF_RST;
      slow_attack_coef  <= erss_pkg::SLOW_ATTACK_RST;
      slow_release_coef <= erss_pkg::SLOW_RELEASE_RST;
      gain_smooth_coef  <= erss_pkg::GAIN_SMOOTH_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        erss_pkg::REG_BYPASS:       bypass_enable     <= pwdata[0];
        erss_pkg::REG_FAST_COEF:    fast_coef         <= pwdata[CB-1:0];
        erss_pkg::REG_SLOW_ATTACK:  slow_attack_coef  <= pwdata[CB-1:0];
        erss_pkg::REG_SLOW_RELEASE: slow_release_coef <= pwdata[CB-1:0];
        erss_pkg::REG_GAIN_SMOOTH:  gain_smooth_coef  <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      erss_pkg::REG_BYPASS:       prdata = {31'd0, bypass_enable};
      erss_pkg::REG_FAST_COEF:    prdata = 32'(fast_coef);
      erss_pkg::REG_SLOW_ATTACK:  prdata = 32'(slow_attack_coef);
      erss_pkg::REG_SLOW_RELEASE: prdata = 32'(slow_release_coef);
      erss_pkg::REG_GAIN_SMOOTH:  prdata = 32'(gain_smooth_coef);
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------
  logic [3:0]           state;
  logic                 ch;          // 0 = left, 1 = right
  logic [SB-1:0]        in_left;
  logic [SB-1:0]        in_right;
  logic signed [SB-1:0] x_reg;       // current sample
  logic [SB-1:0]        mag;         // its magnitude, up to ONE
  logic [SB-1:0]        fe_new;
  logic [SB-1:0]        se_new;
  logic [SB-1:0]        g_new;
  logic [SB-1:0]        divisor;
  logic [SB-1:0]        rem;
  logic [SB-1:0]        quo;         // quotient, then the clamped target gain
  logic [NB-1:0]        cnt;
  logic signed [PB-1:0] prod;
  logic [SB-1:0]        res_left;
  logic [SB-1:0]        res_right;
  logic                 out_valid;
  logic [2*SB-1:0]      out_data;

  // Follower and gain state, one entry per channel.
  logic [SB-1:0] fast_env [2];
  logic [SB-1:0] slow_env [2];
  logic [SB-1:0] sm_gain  [2];

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // ---------------------------------------------------------------------------
  // Shared multiplier. Follower updates are written as x + a*(e - x), so one
  // signed product per update suffices; the output step multiplies x by g.
  // ---------------------------------------------------------------------------
  logic signed [MB-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic [CB-1:0]        slow_sel;

  assign slow_sel = (mag > slow_env[ch]) ? slow_attack_coef : slow_release_coef;

  always_comb begin
    case (state)
      ST_FAST: begin
        mul_a = $signed(MB'(fast_coef));
        mul_b = $signed(MB'(fast_env[ch])) - $signed(MB'(mag));
      end
      ST_SLOW: begin
        mul_a = $signed(MB'(slow_sel));
        mul_b = $signed(MB'(slow_env[ch])) - $signed(MB'(mag));
      end
      ST_GMUL: begin
        mul_a = $signed(MB'(gain_smooth_coef));
        mul_b = $signed(MB'(sm_gain[ch])) - $signed(MB'(quo));
      end
      ST_OMUL: begin
        mul_a = MB'(x_reg);
        mul_b = $signed(MB'(g_new));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounded pole correction; the new value always lies between e and x, so
  // the low SB bits of base + correction are exact.
  logic signed [PB-1:0] pole_sum;
  logic [SB-1:0]        pole_corr;
  assign pole_sum  = prod + POLE_HALF;
  assign pole_corr = pole_sum[CB+SB-1:CB];

  // Output scaling: round half up, then saturate.
  logic signed [PB-1:0]   out_sum;
  logic signed [PB-SB:0]  out_shift;
  logic [SB-1:0]          out_sat;
  assign out_sum   = prod + OUT_HALF;
  assign out_shift = out_sum[PB-1:SB-1];

  always_comb begin
    if (out_shift > SAT_MAX) begin
      out_sat = SAT_MAX[SB-1:0];
    end else if (out_shift < SAT_MIN) begin
      out_sat = SAT_MIN[SB-1:0];
    end else begin
      out_sat = out_shift[SB-1:0];
    end
  end

  // One restoring division step.
  logic [SB:0] rem_dbl;
  logic        rem_ge;
  assign rem_dbl = {rem, 1'b0};
  assign rem_ge  = (rem_dbl >= {1'b0, divisor});

  logic [SB-1:0] cur_sample;
  assign cur_sample = ch ? in_right : in_left;

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ch        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        fast_env[i] <= '0;
        slow_env[i] <= '0;
        sm_gain[i]  <= erss_pkg::ONE_Q;
      end
    end else begin
      // PUSH reloads the output register itself when it is being emptied.
      if (out_valid && m_axis_tready && state != ST_PUSH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            in_left  <= s_axis_tdata[SB-1:0];
            in_right <= s_axis_tdata[2*SB-1:SB];
            ch       <= 1'b0;
            if (bypass_enable) begin
              res_left  <= s_axis_tdata[SB-1:0];
              res_right <= s_axis_tdata[2*SB-1:SB];
              state     <= ST_PUSH;
            end else begin
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          x_reg <= $signed(cur_sample);
          mag   <= cur_sample[SB-1] ? (~cur_sample + SB'(1)) : cur_sample;
          state <= ST_FAST;
        end
        ST_FAST: begin
          prod  <= mul_a * mul_b;
          state <= ST_SLOW;
        end
        ST_SLOW: begin
          fe_new <= mag + pole_corr;
          prod   <= mul_a * mul_b;
          state  <= ST_SEUPD;
        end
        ST_SEUPD: begin
          se_new <= mag + pole_corr;
          state  <= ST_DIVINIT;
        end
        ST_DIVINIT: begin
          // A ratio of unity or more clamps without dividing.
          divisor <= fe_new + erss_pkg::EPS_Q;
          rem     <= se_new;
          cnt     <= NB'(erss_pkg::DIV_STEPS);
          if (se_new >= fe_new + erss_pkg::EPS_Q) begin
            quo   <= erss_pkg::ONE_Q;
            state <= ST_GMUL;
          end else begin
            quo   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_ge) begin
            rem <= SB'(rem_dbl - {1'b0, divisor});
          end else begin
            rem <= rem_dbl[SB-1:0];
          end
          quo <= {quo[SB-2:0], rem_ge};
          cnt <= cnt - NB'(1);
          if (cnt == NB'(1)) begin
            state <= ST_GMUL;
          end
        end
        ST_GMUL: begin
          prod  <= mul_a * mul_b;
          state <= ST_GUPD;
        end
        ST_GUPD: begin
          g_new <= quo + pole_corr;
          state <= ST_OMUL;
        end
        ST_OMUL: begin
          prod  <= mul_a * mul_b;
          state <= ST_ORND;
        end
        ST_ORND: begin
          fast_env[ch] <= fe_new;
          slow_env[ch] <= se_new;
          sm_gain[ch]  <= g_new;
          if (ch) begin
            res_right <= out_sat;
            state     <= ST_PUSH;
          end else begin
            res_left <= out_sat;
            ch       <= 1'b1;
            state    <= ST_LOAD;
          end
        end
        ST_PUSH: begin
          // Wait until the output register is free or is being emptied.
          if (!out_valid || m_axis_tready) begin
            out_data  <= {res_right, res_left};
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
